// ===== hw/rtl/mblq_pkg.sv =====
// ----------------------------------------------------------------------------
// mblq_pkg
// Shared constants and types of the measure bucket list queue.
// ----------------------------------------------------------------------------
package mblq_pkg;

  localparam int POINT_COUNT_DEF    = 1024;
  localparam int MEASURE_LEVELS_DEF = 256;
  localparam int GROUP_SIZE         = 16;

  localparam logic KIND_ENTER  = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  // per-state commands from controller to datapath
  typedef struct packed {
    logic latch;
    logic rd;
    logic upd;
    logic upd2;
    logic scan1;
    logic scan2;
    logic rdf;
  } cmd_t;

  typedef struct packed {
    logic need_upd2;
  } stat_t;

endpackage

// ===== hw/rtl/mblq_ctrl.sv =====
// ----------------------------------------------------------------------------
// mblq_ctrl
// Sequencer: read, update links, scan open buckets, fetch head, report.
// ----------------------------------------------------------------------------
module mblq_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  mblq_pkg::stat_t stat,
  output mblq_pkg::cmd_t cmd,
  output logic           busy,
  output logic           out_valid
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD    = 3'd1;
  localparam logic [2:0] S_UPD   = 3'd2;
  localparam logic [2:0] S_UPD2  = 3'd3;
  localparam logic [2:0] S_SCAN1 = 3'd4;
  localparam logic [2:0] S_SCAN2 = 3'd5;
  localparam logic [2:0] S_RDF   = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (start) state_nxt = S_RD;
      S_RD:    state_nxt = S_UPD;
      S_UPD:   state_nxt = stat.need_upd2 ? S_UPD2 : S_SCAN1;
      S_UPD2:  state_nxt = S_SCAN1;
      S_SCAN1: state_nxt = S_SCAN2;
      S_SCAN2: state_nxt = S_RDF;
      S_RDF:   state_nxt = S_OUT;
      S_OUT:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);

  assign cmd.latch = (state_r == S_IDLE) && start;
  assign cmd.rd    = (state_r == S_RD);
  assign cmd.upd   = (state_r == S_UPD);
  assign cmd.upd2  = (state_r == S_UPD2);
  assign cmd.scan1 = (state_r == S_SCAN1);
  assign cmd.scan2 = (state_r == S_SCAN2);
  assign cmd.rdf   = (state_r == S_RDF);

endmodule

// ===== hw/rtl/mblq_dp.sv =====
// ----------------------------------------------------------------------------
// mblq_dp
// Link memories, bucket head/tail memories, open bits and top scan.
// ----------------------------------------------------------------------------
module mblq_dp #(
  parameter int POINT_COUNT    = mblq_pkg::POINT_COUNT_DEF,
  parameter int MEASURE_LEVELS = mblq_pkg::MEASURE_LEVELS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  mblq_pkg::cmd_t  cmd,
  output mblq_pkg::stat_t stat,
  input  logic            in_kind,
  input  logic [7:0]      in_measure,
  input  logic [9:0]      in_point,
  output logic            out_status,
  output logic            out_top_valid,
  output logic [7:0]      out_top_measure,
  output logic [9:0]      out_top_point
);

  localparam int PW = $clog2(POINT_COUNT);
  localparam int MW = $clog2(MEASURE_LEVELS);
  localparam int GS = mblq_pkg::GROUP_SIZE;
  localparam int NG = (MEASURE_LEVELS + GS - 1) / GS;
  localparam int GW = (NG > 1) ? $clog2(NG) : 1;
  localparam int SW = $clog2(GS);
  localparam logic [PW:0] END_MARK = (PW+1)'(POINT_COUNT);

  // memories
  logic [PW:0]   next_mem  [POINT_COUNT];
  logic [PW:0]   prev_mem  [POINT_COUNT];
  logic [PW-1:0] first_mem [MEASURE_LEVELS];
  logic [PW-1:0] last_mem  [MEASURE_LEVELS];
  logic [MEASURE_LEVELS-1:0] open_r;

  logic          kind_r;
  logic [MW-1:0] m_r;
  logic [PW-1:0] p_r;
  logic          open_hit_r;
  logic [PW:0]   succ_q, pred_q;
  logic [PW-1:0] first_q, last_q;
  logic          status_r;
  logic          any_r, top_valid_r;
  logic [GW-1:0] grp_r;
  logic [MW-1:0] top_m_r;

  // update-step write controls
  logic          nx_we, pv_we, fs_we, ls_we, op_we, op_wd;
  logic [PW-1:0] nx_wa, pv_wa;
  logic [PW:0]   nx_wd, pv_wd;
  logic [PW-1:0] fs_wd, ls_wd;
  logic [PW:0]   p_ext;

  function automatic logic is_pt(input logic [PW:0] v);
    return v < END_MARK;
  endfunction

  assign p_ext = {1'b0, p_r};
  assign stat.need_upd2 = (kind_r == mblq_pkg::KIND_ENTER) && open_hit_r;

  always_comb begin
    nx_we = 1'b0; nx_wa = p_r; nx_wd = END_MARK;
    pv_we = 1'b0; pv_wa = p_r; pv_wd = END_MARK;
    fs_we = 1'b0; fs_wd = p_r;
    ls_we = 1'b0; ls_wd = p_r;
    op_we = 1'b0; op_wd = 1'b0;
    if (cmd.upd) begin
      if (kind_r == mblq_pkg::KIND_ENTER) begin
        if (open_hit_r) begin
          nx_we = is_pt({1'b0, last_q});
          nx_wa = last_q;
          nx_wd = p_ext;
          pv_we = 1'b1;
          pv_wd = {1'b0, last_q};
          ls_we = 1'b1;
        end else begin
          op_we = 1'b1; op_wd = 1'b1;
          fs_we = 1'b1; ls_we = 1'b1;
          nx_we = 1'b1; pv_we = 1'b1;
        end
      end else if (open_hit_r) begin
        priority if (first_q == p_r && last_q == p_r) begin
          op_we = 1'b1;
        end else if (first_q == p_r) begin
          fs_we = 1'b1; fs_wd = PW'(succ_q);
          pv_we = is_pt(succ_q); pv_wa = PW'(succ_q);
        end else if (last_q == p_r) begin
          ls_we = 1'b1; ls_wd = PW'(pred_q);
          nx_we = is_pt(pred_q); nx_wa = PW'(pred_q);
        end else begin
          nx_we = is_pt(pred_q); nx_wa = PW'(pred_q); nx_wd = succ_q;
          pv_we = is_pt(succ_q); pv_wa = PW'(succ_q); pv_wd = pred_q;
        end
      end
    end else if (cmd.upd2) begin
      // tail's forward link goes first, so the new point's end mark wins
      nx_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      kind_r <= in_kind;
      m_r    <= MW'(in_measure % MEASURE_LEVELS);
      p_r    <= PW'(in_point % POINT_COUNT);
    end
    if (cmd.rd) begin
      succ_q     <= next_mem[p_r];
      pred_q     <= prev_mem[p_r];
      last_q     <= last_mem[m_r];
      open_hit_r <= open_r[m_r];
      status_r   <= (kind_r == mblq_pkg::KIND_REMOVE) && !open_r[m_r];
    end
    if (cmd.rd)       first_q <= first_mem[m_r];
    else if (cmd.rdf) first_q <= first_mem[top_m_r];
    if (nx_we) next_mem[nx_wa] <= nx_wd;
    if (pv_we) prev_mem[pv_wa] <= pv_wd;
    if (fs_we) first_mem[m_r]  <= fs_wd;
    if (ls_we) last_mem[m_r]   <= ls_wd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) open_r <= '0;
    else if (op_we) open_r[m_r] <= op_wd;
  end

  // two-step highest-open search: group, then bit inside group
  logic [NG*GS-1:0] open_pad;
  logic [NG-1:0]    grp_any;
  logic [GW-1:0]    grp_hi;
  logic             any_c;
  logic [GS-1:0]    grp_bits;
  logic [SW-1:0]    bit_hi;

  assign open_pad = (NG*GS)'(open_r);

  always_comb begin
    grp_hi = '0;
    any_c  = 1'b0;
    for (int g = 0; g < NG; g++) begin
      grp_any[g] = |open_pad[g*GS +: GS];
      if (grp_any[g]) begin
        grp_hi = GW'(g);
        any_c  = 1'b1;
      end
    end
  end

  assign grp_bits = open_pad[grp_r*GS +: GS];

  always_comb begin
    bit_hi = '0;
    for (int i = 0; i < GS; i++) begin
      if (grp_bits[i]) bit_hi = SW'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan1) begin
      grp_r <= grp_hi;
      any_r <= any_c;
    end
    if (cmd.scan2) begin
      top_m_r     <= any_r ? MW'({grp_r, bit_hi}) : '0;
      top_valid_r <= any_r;
    end
  end

  assign out_status      = status_r;
  assign out_top_valid   = top_valid_r;
  assign out_top_measure = 8'(top_m_r);
  assign out_top_point   = top_valid_r ? 10'(first_q) : 10'd0;

endmodule

// ===== hw/rtl/measure_bucket_list_queue_top.sv =====
// ----------------------------------------------------------------------------
// measure_bucket_list_queue_top
// Bucket priority queue of points keyed by measure, one report per item.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy low. out_valid pulses for one
// cycle with the result after the read, update, two-level open-bucket scan
// and head-memory read steps; an enter into an open bucket adds a second
// update step, as it writes the forward link memory twice through its
// single port. busy drops the cycle after out_valid, so a new item is not
// accepted until the previous one has been reported.
// The result must be taken in the cycle it is shown: there is no hold-off.
module measure_bucket_list_queue_top #(
  parameter int POINT_COUNT    = mblq_pkg::POINT_COUNT_DEF,
  parameter int MEASURE_LEVELS = mblq_pkg::MEASURE_LEVELS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic       in_kind,
  input  logic [7:0] in_measure,
  input  logic [9:0] in_point,
  output logic       out_valid,
  output logic       out_status,
  output logic       out_top_valid,
  output logic [7:0] out_top_measure,
  output logic [9:0] out_top_point
);

  mblq_pkg::cmd_t  cmd;
  mblq_pkg::stat_t stat;

  mblq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  mblq_dp #(
    .POINT_COUNT    (POINT_COUNT),
    .MEASURE_LEVELS (MEASURE_LEVELS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_kind         (in_kind),
    .in_measure      (in_measure),
    .in_point        (in_point),
    .out_status      (out_status),
    .out_top_valid   (out_top_valid),
    .out_top_measure (out_top_measure),
    .out_top_point   (out_top_point)
  );

endmodule

// ===== hw/rtl/mblq_checker.sv =====
// ----------------------------------------------------------------------------
// mblq_checker
// Port-level checks of the bucket queue, bound to the top level.
// ----------------------------------------------------------------------------
module mblq_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic       out_top_valid,
  input logic [7:0] out_top_measure,
  input logic [9:0] out_top_point
);

  // an accepted item keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("accept did not raise busy");

  // a result only ends a busy period
  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy ##1 !busy) else $error("result outside item");

  // one result per item
  a_out_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result repeated");

  // empty queue reports zeros
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_top_valid |-> out_top_measure == 8'd0 && out_top_point == 10'd0)
    else $error("empty queue with nonzero top");

endmodule

bind measure_bucket_list_queue_top mblq_checker u_mblq_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_top_valid   (out_top_valid),
  .out_top_measure (out_top_measure),
  .out_top_point   (out_top_point)
);
